>>> rtl/clle_pkg.sv
package clle_pkg;

  localparam int NODES      = 256;
  localparam int NODE_BITS  = $clog2(NODES);
  localparam int VALUE_BITS = 32;
  localparam int OP_BITS    = 3;
  localparam int POS_BITS   = 8;
  localparam int COUNT_BITS = 8;

  localparam logic [NODE_BITS-1:0] FREE_NODE = '0;
  localparam logic [NODE_BITS-1:0] HEAD_NODE = NODE_BITS'(NODES - 1);

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_FIND   = 3'd3,
    OP_LENGTH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_BITS-1:0]           op;
    logic [POS_BITS-1:0]          position;
    logic signed [VALUE_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [POS_BITS-1:0]          found_position;
    logic [COUNT_BITS-1:0]        count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_INS_WR1,
    S_INS_WR2,
    S_DEL_WR1,
    S_DEL_WR2,
    S_GET_DONE,
    S_FIND_FIRST,
    S_FIND
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_LINK,
    RD_FREE
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_FREE,
    WA_CUR,
    WA_T
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_T,
    WD_LINK,
    WD_FREE
  } wd_sel_t;

  typedef struct packed {
    logic    req_load;
    rd_sel_t rd_sel;
    logic    lk_we;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    val_we;
    logic    cur_head;
    logic    cur_link;
    logic    t_link;
    logic    free_t;
    logic    cnt_pos;
    logic    cnt_one;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    count_inc;
    logic    count_dec;
    logic    done;
    status_t res_status;
    logic    sel_read;
    logic    sel_found;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               pos_zero;
    logic               pos_gt_count;
    logic               pos_gt_count1;
    logic               free_empty;
    logic               count_zero;
    logic               cnt_zero;
    logic               cnt_eq_count;
    logic               value_match;
  } dp_stat_t;

endpackage

>>> rtl/clle_datapath.sv
module clle_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  clle_pkg::in_word_t  in_word,
  input  clle_pkg::dp_cmd_t   cmd,
  output clle_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output clle_pkg::out_word_t out_word
);
  import clle_pkg::*;

  logic [NODE_BITS-1:0]  link_mem [NODES];
  logic [VALUE_BITS-1:0] value_mem [NODES];
  logic [NODES-1:0]      link_valid_r;

  logic [NODE_BITS-1:0]  link_q_r;
  logic                  lvalid_q_r;
  logic [NODE_BITS-1:0]  raddr_q_r;
  logic [VALUE_BITS-1:0] value_q_r;

  in_word_t              req_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [NODE_BITS-1:0]  free_r;
  logic [NODE_BITS-1:0]  cur_r;
  logic [NODE_BITS-1:0]  t_r;
  logic [POS_BITS-1:0]   cnt_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;

  logic [NODE_BITS-1:0]  link_data;
  logic [NODE_BITS-1:0]  rd_addr;
  logic [NODE_BITS-1:0]  wr_addr;
  logic [NODE_BITS-1:0]  wr_data;

  // never-written entries hold the power-up chain: i -> i+1, last free node and header -> end
  function automatic logic [NODE_BITS-1:0] reset_link(input logic [NODE_BITS-1:0] a);
    logic [NODE_BITS-1:0] r;
    if (a < NODE_BITS'(NODES - 2)) begin
      r = NODE_BITS'(a + 1'b1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign link_data = lvalid_q_r ? link_q_r : reset_link(raddr_q_r);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: rd_addr = HEAD_NODE;
      RD_FREE: rd_addr = free_r;
      default: rd_addr = link_data;
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      WA_CUR:  wr_addr = cur_r;
      WA_T:    wr_addr = t_r;
      default: wr_addr = free_r;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_LINK: wr_data = link_data;
      WD_FREE: wr_data = free_r;
      default: wr_data = t_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_we) begin
      link_mem[wr_addr] <= wr_data;
    end
    link_q_r   <= link_mem[rd_addr];
    lvalid_q_r <= link_valid_r[rd_addr];
    raddr_q_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.val_we) begin
      value_mem[free_r] <= req_r.value;
    end
    value_q_r <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_valid_r <= '0;
    end else if (cmd.lk_we) begin
      link_valid_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc) begin
      count_nxt = COUNT_BITS'(count_r + 1'b1);
    end else if (cmd.count_dec) begin
      count_nxt = COUNT_BITS'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      free_r  <= NODE_BITS'(1);
    end else begin
      count_r <= count_nxt;
      if (cmd.free_t) begin
        free_r <= t_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_word;
    end
    if (cmd.cur_head) begin
      cur_r <= HEAD_NODE;
    end else if (cmd.cur_link) begin
      cur_r <= link_data;
    end
    if (cmd.t_link) begin
      t_r <= link_data;
    end
    if (cmd.cnt_pos) begin
      cnt_r <= POS_BITS'(req_r.position - 1'b1);
    end else if (cmd.cnt_one) begin
      cnt_r <= POS_BITS'(1);
    end else if (cmd.cnt_inc) begin
      cnt_r <= POS_BITS'(cnt_r + 1'b1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= POS_BITS'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_word_r.status         <= cmd.res_status;
      out_word_r.read_value     <= cmd.sel_read ? value_q_r : '0;
      out_word_r.found_position <= cmd.sel_found ? cnt_r : '0;
      out_word_r.count          <= count_nxt;
    end
  end

  assign stat.op            = req_r.op;
  assign stat.pos_zero      = (req_r.position == '0);
  assign stat.pos_gt_count  = (req_r.position > count_r);
  assign stat.pos_gt_count1 = ({1'b0, req_r.position} > ({1'b0, count_r} + 9'd1));
  assign stat.free_empty    = (free_r == FREE_NODE);
  assign stat.count_zero    = (count_r == '0);
  assign stat.cnt_zero      = (cnt_r == '0);
  assign stat.cnt_eq_count  = (cnt_r == count_r);
  assign stat.value_match   = (value_q_r == req_r.value);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/clle_ctrl.sv
module clle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  clle_pkg::dp_stat_t stat,
  output clle_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import clle_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.pos_zero || stat.pos_gt_count1 || stat.free_empty) state_nxt = S_IDLE;
            else state_nxt = S_WALK;
          end
          OP_DELETE, OP_GET: begin
            if (stat.pos_zero || stat.pos_gt_count) state_nxt = S_IDLE;
            else state_nxt = S_WALK;
          end
          OP_FIND: begin
            if (stat.count_zero) state_nxt = S_IDLE;
            else state_nxt = S_FIND_FIRST;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WALK: begin
        if (stat.cnt_zero) begin
          unique case (stat.op)
            OP_INSERT: state_nxt = S_INS_WR1;
            OP_DELETE: state_nxt = S_DEL_WR1;
            default:   state_nxt = S_GET_DONE;
          endcase
        end
      end
      S_INS_WR1:    state_nxt = S_INS_WR2;
      S_DEL_WR1:    state_nxt = S_DEL_WR2;
      S_INS_WR2, S_DEL_WR2, S_GET_DONE: state_nxt = S_IDLE;
      S_FIND_FIRST: state_nxt = S_FIND;
      S_FIND: begin
        if (stat.value_match || stat.cnt_eq_count) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_LINK;
    cmd.wa_sel = WA_FREE;
    cmd.wd_sel = WD_T;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.req_load = start;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_INSERT: begin
            priority if (stat.pos_zero || stat.pos_gt_count1) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_BAD_POS;
            end else if (stat.free_empty) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_FULL;
            end else begin
              cmd.rd_sel   = RD_HEAD;
              cmd.cur_head = 1'b1;
              cmd.cnt_pos  = 1'b1;
            end
          end
          OP_DELETE, OP_GET: begin
            if (stat.pos_zero || stat.pos_gt_count) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_BAD_POS;
            end else begin
              cmd.rd_sel   = RD_HEAD;
              cmd.cur_head = 1'b1;
              cmd.cnt_pos  = 1'b1;
            end
          end
          OP_FIND: begin
            if (stat.count_zero) begin
              cmd.done       = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
            end else begin
              cmd.rd_sel  = RD_HEAD;
              cmd.cnt_one = 1'b1;
            end
          end
          default: begin
            cmd.done = 1'b1;
          end
        endcase
      end
      S_WALK: begin
        // cur is the predecessor once the count runs out; link data is its successor
        if (stat.cnt_zero) begin
          unique case (stat.op)
            OP_INSERT: begin
              cmd.t_link = 1'b1;
              cmd.rd_sel = RD_FREE;
            end
            OP_DELETE: begin
              cmd.t_link = 1'b1;
              cmd.rd_sel = RD_LINK;
            end
            default: begin
              cmd.rd_sel = RD_LINK;
            end
          endcase
        end else begin
          cmd.cur_link = 1'b1;
          cmd.rd_sel   = RD_LINK;
          cmd.cnt_dec  = 1'b1;
        end
      end
      S_INS_WR1: begin
        // splice the new node ahead of the old successor, keep the next free node
        cmd.lk_we  = 1'b1;
        cmd.wa_sel = WA_FREE;
        cmd.wd_sel = WD_T;
        cmd.val_we = 1'b1;
        cmd.t_link = 1'b1;
      end
      S_INS_WR2: begin
        cmd.lk_we     = 1'b1;
        cmd.wa_sel    = WA_CUR;
        cmd.wd_sel    = WD_FREE;
        cmd.free_t    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.done      = 1'b1;
      end
      S_DEL_WR1: begin
        // bypass the removed node
        cmd.lk_we  = 1'b1;
        cmd.wa_sel = WA_CUR;
        cmd.wd_sel = WD_LINK;
      end
      S_DEL_WR2: begin
        cmd.lk_we     = 1'b1;
        cmd.wa_sel    = WA_T;
        cmd.wd_sel    = WD_FREE;
        cmd.free_t    = 1'b1;
        cmd.count_dec = 1'b1;
        cmd.done      = 1'b1;
      end
      S_GET_DONE: begin
        cmd.done     = 1'b1;
        cmd.sel_read = 1'b1;
      end
      S_FIND_FIRST: begin
        cmd.rd_sel = RD_LINK;
      end
      S_FIND: begin
        priority if (stat.value_match) begin
          cmd.done      = 1'b1;
          cmd.sel_found = 1'b1;
        end else if (stat.cnt_eq_count) begin
          cmd.done       = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
        end else begin
          cmd.rd_sel  = RD_LINK;
          cmd.cnt_inc = 1'b1;
        end
      end
      default: begin
        cmd.done = 1'b0;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/cursor_linked_list_engine_top.sv
// Array-held singly linked list with a free chain in the same link memory: a word on
// in_word (op, position, value) is taken when start is high and busy is low, and exactly
// one result word appears on out_word with out_valid high for a single cycle; the
// receiver cannot stall, so capture it on that cycle. Insert, delete, get and find walk the link
// memory one node per cycle through its registered read port; insert and delete then write
// two links, get returns the value at the position reached, and find compares each node's
// value until a match or the end of the list. Length and rejected requests finish in the
// decode step. busy stays high from the cycle after accept until the result strobe, which
// is the first cycle a new word can be taken.
module cursor_linked_list_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  clle_pkg::in_word_t  in_word,
  output logic                out_valid,
  output clle_pkg::out_word_t out_word
);
  import clle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  clle_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> rtl/clle_checker.sv
module clle_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input clle_pkg::out_word_t out_word
);
  import clle_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("operation ended without a result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.count <= COUNT_BITS'(NODES - 2))
    else $error("element count beyond list capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |->
      out_word.read_value == '0 && out_word.found_position == '0)
    else $error("failed request carried data");

endmodule

bind cursor_linked_list_engine_top clle_checker u_chk (.*);
